### rtl/core/response_time_analysis_macros.svh
// ----------------------------------------------------------------------------
// Response time analysis assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_TIME_ANALYSIS_MACROS_SVH
`define RESPONSE_TIME_ANALYSIS_MACROS_SVH

// Same-cycle implication
`define RTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rta_pkg.sv
// ----------------------------------------------------------------------------
// Response time analysis package
// Shared widths, defaults, outcome codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rta_pkg;

  // Field widths
  localparam int C_W = 16;  // execution time and period
  localparam int R_W = 32;  // response time

  // Parameter defaults
  localparam int MAX_TASKS_DEF = 8;
  localparam int MAX_ITER_DEF  = 100;

  // Result codes
  typedef enum logic [1:0] {
    OC_CONVERGED  = 2'd0,
    OC_EXCEEDED   = 2'd1,
    OC_ITER_LIMIT = 2'd2,
    OC_TABLE_FULL = 2'd3
  } outcome_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS,
    ST_READ,
    ST_DIVINIT,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_EVAL,
    ST_FIN
  } state_t;

endpackage

### rtl/core/rta_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/response_time_analysis.sv
// ----------------------------------------------------------------------------
// Response time analysis
// Fixed-priority response-time iteration over a table of stored tasks.
// ----------------------------------------------------------------------------
// Tasks arrive highest priority first, one per transaction; tuser set clears
// the table before the task. For each task the block iterates
// R = C + sum(ceil(R/T_j) * C_j) over the stored tasks, starting at R = C,
// until R repeats, R exceeds the task's period, or MAX_ITER passes are done,
// then appends the task to the table. A task arriving with MAX_TASKS entries
// stored is reported as table full and not stored. For every stored task a
// pass goes through a table read, divider setup, a 32-step bit-serial
// divider, one multiply and one accumulate, and each pass adds a pass setup
// state and an evaluate state; a table-full task goes from accept straight
// to the output stage. The input is not ready while a task is analysed; one
// finished result may wait in the output register while the next task is
// taken.
`timescale 1ns / 1ps
`include "response_time_analysis_macros.svh"

module response_time_analysis #(
  parameter int MAX_TASKS = rta_pkg::MAX_TASKS_DEF,
  parameter int MAX_ITER  = rta_pkg::MAX_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // exec_ticks[15:0], task_period[31:16]
  input  logic        s_tuser,   // first[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // response_ticks[31:0], outcome[33:32],
                                 // schedulable[34], zero[39:35]
);

  localparam int C_W    = rta_pkg::C_W;
  localparam int R_W    = rta_pkg::R_W;
  localparam int P_W    = R_W + C_W;
  localparam int AW     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int PASS_W = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;

  rta_pkg::state_t   state, state_next;
  rta_pkg::outcome_t code;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  j;
  logic [PASS_W-1:0] pass;
  logic [4:0]        bitcnt;
  logic [C_W-1:0]    c_reg, t_reg, hp_c, divisor, rem;
  logic [R_W-1:0]    r, quo, rn, ceil_q;
  logic [R_W:0]      acc;
  logic [P_W-1:0]    prod;
  logic [P_W:0]      acc_sum;
  logic [C_W:0]      rem_sh, rem_diff;
  logic              accept, full_in, out_free, eval_done;
  logic [CNT_W-1:0]  count_in;

  logic              ram_we;
  logic [2*C_W-1:0]  ram_rdata;

  logic [R_W-1:0]    out_resp;
  rta_pkg::outcome_t out_code;
  logic              out_sched;

  // Table of higher-priority tasks: {period, exec}
  rta_ram #(
    .WIDTH (2 * C_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({t_reg, c_reg}),
    .raddr (j[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Shared helper terms
  assign accept    = s_tvalid && s_tready;
  assign count_in  = s_tuser ? '0 : count;
  assign full_in   = (count_in >= CNT_W'(MAX_TASKS));
  assign out_free  = !m_tvalid || m_tready;
  assign rn        = acc[R_W] ? '1 : acc[R_W-1:0];
  assign eval_done = (rn == r) || (rn > R_W'(t_reg)) || (pass == PASS_W'(MAX_ITER - 1));
  assign rem_sh    = {rem, quo[R_W-1]};
  assign rem_diff  = rem_sh - {1'b0, divisor};
  assign ceil_q    = quo + R_W'(rem != '0);
  assign acc_sum   = (P_W + 1)'(acc[R_W-1:0]) + (P_W + 1)'(prod);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      rta_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = full_in ? rta_pkg::ST_FIN : rta_pkg::ST_PASS;
        end
      end
      rta_pkg::ST_PASS: begin
        state_next = (count == '0) ? rta_pkg::ST_EVAL : rta_pkg::ST_READ;
      end
      rta_pkg::ST_READ:    state_next = rta_pkg::ST_DIVINIT;
      rta_pkg::ST_DIVINIT: state_next = rta_pkg::ST_DIV;
      rta_pkg::ST_DIV: begin
        if (bitcnt == 5'd31) begin
          state_next = rta_pkg::ST_MUL;
        end
      end
      rta_pkg::ST_MUL: state_next = rta_pkg::ST_ACC;
      rta_pkg::ST_ACC: begin
        state_next = (j + 1'b1 == count) ? rta_pkg::ST_EVAL : rta_pkg::ST_READ;
      end
      rta_pkg::ST_EVAL: begin
        if (eval_done) begin
          ram_we     = 1'b1;
          state_next = rta_pkg::ST_FIN;
        end else begin
          state_next = rta_pkg::ST_PASS;
        end
      end
      rta_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = rta_pkg::ST_IDLE;
        end
      end
      default: state_next = rta_pkg::ST_IDLE;
    endcase
  end

  // Stored task count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && s_tuser) begin
      count <= '0;
    end else if (ram_we) begin
      count <= count + 1'b1;
    end
  end

  // Datapath: iteration, serial divider, multiply and accumulate
  always_ff @(posedge clk) begin
    unique case (state)
      rta_pkg::ST_IDLE: begin
        if (accept) begin
          c_reg <= s_tdata[C_W-1:0];
          t_reg <= s_tdata[2*C_W-1:C_W];
          pass  <= '0;
          if (full_in) begin
            r    <= '0;
            code <= rta_pkg::OC_TABLE_FULL;
          end else begin
            r <= R_W'(s_tdata[C_W-1:0]);
          end
        end
      end
      rta_pkg::ST_PASS: begin
        acc <= (R_W + 1)'(c_reg);
        j   <= '0;
      end
      rta_pkg::ST_READ: ;
      rta_pkg::ST_DIVINIT: begin
        hp_c    <= ram_rdata[C_W-1:0];
        // stored period of zero divides as one
        divisor <= (ram_rdata[2*C_W-1:C_W] == '0) ? C_W'(1) : ram_rdata[2*C_W-1:C_W];
        rem     <= '0;
        quo     <= r;
        bitcnt  <= '0;
      end
      rta_pkg::ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!rem_diff[C_W]) begin
          rem <= rem_diff[C_W-1:0];
          quo <= {quo[R_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[C_W-1:0];
          quo <= {quo[R_W-2:0], 1'b0};
        end
        bitcnt <= bitcnt + 1'b1;
      end
      rta_pkg::ST_MUL: begin
        prod <= P_W'(ceil_q) * P_W'(hp_c);
      end
      rta_pkg::ST_ACC: begin
        // saturating sum, bit R_W marks overflow
        if (acc[R_W] || (acc_sum[P_W:R_W] != '0)) begin
          acc <= {1'b1, {R_W{1'b1}}};
        end else begin
          acc <= {1'b0, acc_sum[R_W-1:0]};
        end
        j <= j + 1'b1;
      end
      rta_pkg::ST_EVAL: begin
        pass <= pass + 1'b1;
        if (rn == r) begin
          code <= rta_pkg::OC_CONVERGED;
        end else begin
          r <= rn;
          if (rn > R_W'(t_reg)) begin
            code <= rta_pkg::OC_EXCEEDED;
          end else begin
            code <= rta_pkg::OC_ITER_LIMIT;
          end
        end
      end
      rta_pkg::ST_FIN: begin
        if (out_free) begin
          out_resp  <= r;
          out_code  <= code;
          out_sched <= (code != rta_pkg::OC_TABLE_FULL) && (r <= R_W'(t_reg));
        end
      end
      default: ;
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == rta_pkg::ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'b0, out_sched, out_code, out_resp};

  // Assertions
  `RTA_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_TASKS), "count above table size")
  `RTA_ASSERT_NOW(a_div_rem, state == rta_pkg::ST_DIV, rem < divisor, "remainder out of range")
  `RTA_ASSERT_NEXT(a_busy, accept, state != rta_pkg::ST_IDLE, "idle after transaction")
  `RTA_ASSERT_NOW(a_full_out,
                  m_tvalid && out_code == rta_pkg::OC_TABLE_FULL,
                  out_resp == '0 && !out_sched,
                  "table full result not cleared")
  `RTA_ASSERT_NOW(a_exceed_out,
                  m_tvalid && out_code == rta_pkg::OC_EXCEEDED,
                  !out_sched,
                  "exceeded period marked schedulable")

endmodule
